// ===== rtl/core/hld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hld_pkg
// Shared types and constants of the heavy-light decomposition query engine.
// ----------------------------------------------------------------------------
package hld_pkg;

    localparam int VTX_W            = 10;
    localparam int DEF_NUM_VERTICES = 1024;
    localparam int MAX_RESULTS      = 24;
    localparam int CLIMB_W          = $clog2(MAX_RESULTS);

    // no further climb is allowed once this many have been done
    localparam logic [CLIMB_W-1:0] CLIMB_LAST = CLIMB_W'(MAX_RESULTS - 1);

    typedef logic [VTX_W-1:0] vtx_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_VPATH = 2'd1,
        CMD_EPATH = 2'd2,
        CMD_LCA   = 2'd3
    } cmd_t;

    // one vertex entry of the decomposition table
    typedef struct packed {
        vtx_t pos;
        vtx_t head;
        vtx_t parent;
        logic root;
    } entry_t;

    typedef struct packed {
        logic   en;
        vtx_t   vertex;
        entry_t entry;
    } wr_req_t;

    typedef struct packed {
        logic en;
        vtx_t vertex;
    } rd_req_t;

endpackage

// ===== rtl/core/hld_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hld_table
// Vertex table memory: one write port, one registered read port, range
// masking of vertex numbers and a clearing sweep of the root flags after reset.
// ----------------------------------------------------------------------------
module hld_table
    import hld_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  wr_req_t wr_req,
    input  rd_req_t rd_req,
    output entry_t  rd_entry,
    output logic    busy
);

    localparam int              AW        = $clog2(NUM_VERTICES);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(NUM_VERTICES - 1);

    entry_t        mem [NUM_VERTICES];
    logic [AW-1:0] clr_addr_reg;
    logic          busy_reg;
    entry_t        rd_q_reg;
    logic          rd_ok_reg;

    logic          wr_ok;
    logic          rd_ok;
    logic          wr_fire;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    assign wr_ok   = 32'(wr_req.vertex) < 32'(NUM_VERTICES);
    assign rd_ok   = 32'(rd_req.vertex) < 32'(NUM_VERTICES);
    assign wr_fire = busy_reg || (wr_req.en && wr_ok);
    assign wr_addr = busy_reg ? clr_addr_reg : AW'(wr_req.vertex);
    assign wr_data = busy_reg ? entry_t'('0) : wr_req.entry;
    assign busy    = busy_reg;

    // clearing sweep, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
                busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            mem[wr_addr] <= wr_data;
        if (rd_req.en)
        begin
            rd_q_reg  <= mem[AW'(rd_req.vertex)];
            rd_ok_reg <= rd_ok;
        end
    end

    // a vertex outside the table reads as a root at position 0
    always_comb
    begin
        if (rd_ok_reg)
            rd_entry = rd_q_reg;
        else
        begin
            rd_entry.pos    = '0;
            rd_entry.head   = '0;
            rd_entry.parent = '0;
            rd_entry.root   = 1'b1;
        end
    end

endmodule

// ===== rtl/core/hld_path_query_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hld_path_query_engine
// Heavy-light decomposition path query engine: vertex table plus query walker.
// ----------------------------------------------------------------------------
// Software loads each vertex's position, chain head, parent and root flag with
// a write transfer (cmd 0), which gives no result. A
// vertex-path query (cmd 1) returns one inclusive position range per chain on
// the path, an edge-path query (cmd 2) does the same without the common
// ancestor's own position, and an lca query (cmd 3) returns one vertex; the
// final result of every query carries last. Ends in different trees, or a
// path needing more than 23 chain climbs, end the answer with an error result.
// All tables live in one single-port-read memory with a registered read port,
// so a query first fetches both end entries, then per chain climbed the chain
// head entry and then the new end's entry, and finally sends the final result;
// it takes longer while the output is stalled. Queries are handled one at a
// time; the next transfer is taken as soon as the last result sits in the
// output register. After reset a clearing sweep over all NUM_VERTICES entries
// resets the root flags, and input stays stalled until it is done.
// ----------------------------------------------------------------------------
module hld_path_query_engine
    import hld_pkg::*;
#(
    parameter int NUM_VERTICES = DEF_NUM_VERTICES
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       cmd,
    input  logic [VTX_W-1:0] vertex_a,
    input  logic [VTX_W-1:0] vertex_b,
    input  logic [VTX_W-1:0] entry_position,
    input  logic [VTX_W-1:0] entry_chain_head,
    input  logic [VTX_W-1:0] entry_parent,
    input  logic             entry_is_root,

    output logic             out_valid,
    input  logic             out_stall,
    output logic [VTX_W-1:0] range_low,
    output logic [VTX_W-1:0] range_high,
    output logic             range_valid,
    output logic [VTX_W-1:0] ancestor,
    output logic             last,
    output logic             error
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,     // entry of first end arrives
        S_RD_V,     // entry of current v arrives, compare chains
        S_RD_HV,    // entry of v's chain head arrives, emit and climb
        S_FINAL     // final result waits for the output register
    } state_t;

    // table interface
    wr_req_t wr_req;
    rd_req_t rd_req;
    entry_t  rd_entry;
    logic    tbl_busy;

    // walker state
    state_t               state_reg,       state_next;
    cmd_t                 cmd_reg,         cmd_next;
    vtx_t                 u_reg,           u_next;
    vtx_t                 v_reg,           v_next;
    vtx_t                 u_pos_reg,       u_pos_next;
    vtx_t                 u_head_reg,      u_head_next;
    vtx_t                 v_pos_reg,       v_pos_next;
    logic                 eq_reg,          eq_next;
    logic [CLIMB_W-1:0]   climbs_reg,      climbs_next;

    // pending final result
    vtx_t                 res_low_reg,     res_low_next;
    vtx_t                 res_high_reg,    res_high_next;
    logic                 res_valid_reg,   res_valid_next;
    vtx_t                 res_anc_reg,     res_anc_next;
    logic                 res_err_reg,     res_err_next;

    // output register
    logic                 out_valid_reg,   out_valid_next;
    vtx_t                 range_low_reg,   range_low_next;
    vtx_t                 range_high_reg,  range_high_next;
    logic                 range_valid_reg, range_valid_next;
    vtx_t                 ancestor_reg,    ancestor_next;
    logic                 last_reg,        last_next;
    logic                 error_reg,       error_next;

    logic in_accept;
    logic out_free;
    logic a_ok;
    logic b_ok;

    // chain compare after the swap
    logic swap;
    logic same;
    vtx_t nu_vert, nu_pos, nu_head;
    vtx_t nv_vert, nv_pos, nv_head;
    vtx_t lo_v;

    // result being moved into the output register this cycle
    logic emit;
    vtx_t e_low, e_high, e_anc;
    logic e_valid, e_last, e_err;

    hld_table #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_req   (wr_req),
        .rd_req   (rd_req),
        .rd_entry (rd_entry),
        .busy     (tbl_busy)
    );

    assign in_stall  = (state_reg != S_IDLE) || tbl_busy;
    assign in_accept = in_valid && !in_stall;
    // output register can take a new result this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign a_ok      = 32'(vertex_a) < 32'(NUM_VERTICES);
    assign b_ok      = 32'(vertex_b) < 32'(NUM_VERTICES);

    // end with the larger position becomes v
    assign swap    = u_pos_reg > rd_entry.pos;
    assign nu_vert = swap ? v_reg         : u_reg;
    assign nu_pos  = swap ? rd_entry.pos  : u_pos_reg;
    assign nu_head = swap ? rd_entry.head : u_head_reg;
    assign nv_vert = swap ? u_reg         : v_reg;
    assign nv_pos  = swap ? u_pos_reg     : rd_entry.pos;
    assign nv_head = swap ? u_head_reg    : rd_entry.head;
    assign same    = u_head_reg == rd_entry.head;

    // lower end of a vertex-path range: chain head or u, whichever is deeper
    assign lo_v = (rd_entry.pos > u_pos_reg) ? rd_entry.pos : u_pos_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        u_next           = u_reg;
        v_next           = v_reg;
        u_pos_next       = u_pos_reg;
        u_head_next      = u_head_reg;
        v_pos_next       = v_pos_reg;
        eq_next          = eq_reg;
        climbs_next      = climbs_reg;
        res_low_next     = res_low_reg;
        res_high_next    = res_high_reg;
        res_valid_next   = res_valid_reg;
        res_anc_next     = res_anc_reg;
        res_err_next     = res_err_reg;

        wr_req           = '0;
        rd_req           = '0;

        emit             = 1'b0;
        e_low            = '0;
        e_high           = '0;
        e_valid          = 1'b0;
        e_anc            = '0;
        e_last           = 1'b0;
        e_err            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd_t'(cmd) == CMD_WRITE)
                    begin
                        wr_req.en           = 1'b1;
                        wr_req.vertex       = vertex_a;
                        wr_req.entry.pos    = entry_position;
                        wr_req.entry.head   = entry_chain_head;
                        wr_req.entry.parent = entry_parent;
                        wr_req.entry.root   = entry_is_root;
                    end
                    else
                    begin
                        cmd_next       = cmd_t'(cmd);
                        u_next         = vertex_a;
                        v_next         = vertex_b;
                        climbs_next    = '0;
                        res_low_next   = '0;
                        res_high_next  = '0;
                        res_valid_next = 1'b0;
                        res_anc_next   = '0;
                        res_err_next   = 1'b0;
                        if (!a_ok || !b_ok)
                        begin
                            res_err_next = 1'b1;
                            state_next   = S_FINAL;
                        end
                        else if (cmd_t'(cmd) == CMD_EPATH && vertex_a == vertex_b)
                            state_next = S_FINAL;
                        else
                        begin
                            rd_req.en     = 1'b1;
                            rd_req.vertex = vertex_a;
                            state_next    = S_RD_A;
                        end
                    end
                end
            end

            S_RD_A:
            begin
                u_pos_next    = rd_entry.pos;
                u_head_next   = rd_entry.head;
                rd_req.en     = 1'b1;
                rd_req.vertex = v_reg;
                state_next    = S_RD_V;
            end

            S_RD_V:
            begin
                u_next      = nu_vert;
                u_pos_next  = nu_pos;
                u_head_next = nu_head;
                v_next      = nv_vert;
                v_pos_next  = nv_pos;
                eq_next     = same;
                if (same && cmd_reg == CMD_LCA)
                begin
                    res_anc_next = nu_vert;
                    state_next   = S_FINAL;
                end
                else if (same && cmd_reg == CMD_EPATH)
                begin
                    // ends met at one vertex: nothing left to cover
                    if (nu_vert != nv_vert)
                    begin
                        res_low_next   = nu_pos + VTX_W'(1);
                        res_high_next  = nv_pos;
                        res_valid_next = 1'b1;
                    end
                    state_next = S_FINAL;
                end
                else if (!same && climbs_reg == CLIMB_LAST)
                begin
                    res_err_next = 1'b1;
                    state_next   = S_FINAL;
                end
                else
                begin
                    rd_req.en     = 1'b1;
                    rd_req.vertex = nv_head;
                    state_next    = S_RD_HV;
                end
            end

            S_RD_HV:
            begin
                if (eq_reg)
                begin
                    // vertex path, both ends on one chain: final range
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_low      = lo_v;
                        e_high     = v_pos_reg;
                        e_valid    = 1'b1;
                        e_last     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (rd_entry.root)
                begin
                    // chain head is a root: ends lie in different trees
                    res_err_next = 1'b1;
                    state_next   = S_FINAL;
                end
                else if (cmd_reg == CMD_LCA || out_free)
                begin
                    if (cmd_reg != CMD_LCA)
                    begin
                        emit    = 1'b1;
                        e_low   = (cmd_reg == CMD_VPATH) ? lo_v : rd_entry.pos;
                        e_high  = v_pos_reg;
                        e_valid = 1'b1;
                    end
                    v_next        = rd_entry.parent;
                    rd_req.en     = 1'b1;
                    rd_req.vertex = rd_entry.parent;
                    climbs_next   = climbs_reg + CLIMB_W'(1);
                    state_next    = S_RD_V;
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_low      = res_low_reg;
                    e_high     = res_high_reg;
                    e_valid    = res_valid_reg;
                    e_anc      = res_anc_reg;
                    e_last     = 1'b1;
                    e_err      = res_err_reg;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // output register: load on emit, drop after the transfer
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        range_low_next   = range_low_reg;
        range_high_next  = range_high_reg;
        range_valid_next = range_valid_reg;
        ancestor_next    = ancestor_reg;
        last_next        = last_reg;
        error_next       = error_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            range_low_next   = e_low;
            range_high_next  = e_high;
            range_valid_next = e_valid;
            ancestor_next    = e_anc;
            last_next        = e_last;
            error_next       = e_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= CMD_WRITE;
            u_reg           <= '0;
            v_reg           <= '0;
            u_pos_reg       <= '0;
            u_head_reg      <= '0;
            v_pos_reg       <= '0;
            eq_reg          <= 1'b0;
            climbs_reg      <= '0;
            res_low_reg     <= '0;
            res_high_reg    <= '0;
            res_valid_reg   <= 1'b0;
            res_anc_reg     <= '0;
            res_err_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            range_low_reg   <= '0;
            range_high_reg  <= '0;
            range_valid_reg <= 1'b0;
            ancestor_reg    <= '0;
            last_reg        <= 1'b0;
            error_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            u_reg           <= u_next;
            v_reg           <= v_next;
            u_pos_reg       <= u_pos_next;
            u_head_reg      <= u_head_next;
            v_pos_reg       <= v_pos_next;
            eq_reg          <= eq_next;
            climbs_reg      <= climbs_next;
            res_low_reg     <= res_low_next;
            res_high_reg    <= res_high_next;
            res_valid_reg   <= res_valid_next;
            res_anc_reg     <= res_anc_next;
            res_err_reg     <= res_err_next;
            out_valid_reg   <= out_valid_next;
            range_low_reg   <= range_low_next;
            range_high_reg  <= range_high_next;
            range_valid_reg <= range_valid_next;
            ancestor_reg    <= ancestor_next;
            last_reg        <= last_next;
            error_reg       <= error_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign range_low   = range_low_reg;
    assign range_high  = range_high_reg;
    assign range_valid = range_valid_reg;
    assign ancestor    = ancestor_reg;
    assign last        = last_reg;
    assign error       = error_reg;

    // clearing sweep runs once after reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !tbl_busy |=> !tbl_busy)
        else $error("table clearing restarted");

    // a range result never carries an error or an ancestor
    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && range_valid_reg) |-> (!error_reg && ancestor_reg == '0))
        else $error("range result with error or ancestor");

    // an error result closes the answer and carries no range
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg) |-> (last_reg && !range_valid_reg))
        else $error("error result not final");

    // second end entry is always fetched right after the first
    a_rd_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_A) |=> (state_reg == S_RD_V))
        else $error("read sequence broken");

    // climb count stays within the result budget
    a_climb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_V || state_reg == S_RD_HV) |-> (climbs_reg <= CLIMB_LAST))
        else $error("climb count overflow");

endmodule
